@@ hw/rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned SEXTET_W        = 6;
  localparam int unsigned PEND_W          = 3 * SEXTET_W;  // three held sextets
  localparam int unsigned GROUP_W         = 4 * SEXTET_W;  // one full group
  localparam int unsigned B64D_FIFO_DEPTH = 4;

  // sextet slot counter inside a group
  localparam logic [1:0] SLOT_LAST = 2'd3;
  // byte index inside a decoded group
  localparam logic [1:0] BYTE_IDX_FIRST = 2'd0;
  localparam logic [1:0] BYTE_IDX_MID   = 2'd1;
  localparam logic [1:0] BYTE_IDX_LAST  = 2'd2;

  // alphabet anchors
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam logic [7:0] OFS_LOWER = 8'd26;
  localparam logic [7:0] OFS_DIGIT = 8'd52;
  localparam logic [5:0] SX_PLUS   = 6'd62;
  localparam logic [5:0] SX_SLASH  = 6'd63;

  typedef struct packed {
    logic                ok;
    logic [SEXTET_W-1:0] val;
  } sextet_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic sextet_t char_to_sextet(input logic [BYTE_W-1:0] ch);
    sextet_t    r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      t     = ch - CH_UPPER_A;
      r.ok  = 1'b1;
      r.val = t[SEXTET_W-1:0];
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      t     = ch - CH_LOWER_A + OFS_LOWER;
      r.ok  = 1'b1;
      r.val = t[SEXTET_W-1:0];
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      t     = ch - CH_DIGIT_0 + OFS_DIGIT;
      r.ok  = 1'b1;
      r.val = t[SEXTET_W-1:0];
    end else if (ch == CH_PLUS) begin
      r.ok  = 1'b1;
      r.val = SX_PLUS;
    end else if (ch == CH_SLASH) begin
      r.ok  = 1'b1;
      r.val = SX_SLASH;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Takes characters, maps them to sextets and packs full groups of four.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [b64d_pkg::BYTE_W-1:0]     in_tdata,
  input  logic                            in_tlast,
  input  b64d_pkg::fifo_stat_t            fifo_stat,
  output logic                            push,
  output logic [b64d_pkg::GROUP_W-1:0]    push_data
);
  import b64d_pkg::*;

  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [1:0]        slot_r, slot_nxt;
  sextet_t           sx;
  logic              accept;

  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign sx        = char_to_sextet(in_tdata);

  assign push      = accept && sx.ok && (slot_r == SLOT_LAST);
  assign push_data = {pend_r, sx.val};

  always_comb begin
    pend_nxt = pend_r;
    slot_nxt = slot_r;
    if (accept) begin
      if (sx.ok) begin
        if (slot_r == SLOT_LAST) begin
          pend_nxt = '0;
          slot_nxt = '0;
        end else begin
          pend_nxt = {pend_r[PEND_W-SEXTET_W-1:0], sx.val};
          slot_nxt = slot_r + 2'd1;
        end
      end
      // end of message drops any partial group
      if (in_tlast) begin
        pend_nxt = '0;
        slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      slot_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

@@ hw/rtl/b64d_fifo.sv @@
// ----------------------------------------------------------------------------
// b64d_fifo
// Short queue of decoded 24-bit groups between front and back.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int unsigned DEPTH = b64d_pkg::B64D_FIFO_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  logic [b64d_pkg::GROUP_W-1:0]    push_data,
  input  logic                            pop,
  output logic [b64d_pkg::GROUP_W-1:0]    pop_data,
  output b64d_pkg::fifo_stat_t            stat
);
  import b64d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_END = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  logic [GROUP_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CNT_MAX);
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_END) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_END) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> !push)
    else $error("push into full group queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.empty |-> !pop)
    else $error("pop from empty group queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("group queue count out of range");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("group queue count missed a push");
`endif

endmodule

@@ hw/rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks each 24-bit group into three output bytes, MSB first.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  b64d_pkg::fifo_stat_t            fifo_stat,
  input  logic [b64d_pkg::GROUP_W-1:0]    pop_data,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [b64d_pkg::BYTE_W-1:0]     out_tdata,
  output logic                            out_tlast
);
  import b64d_pkg::*;

  logic [GROUP_W-1:0] word_r, word_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               busy_r, busy_nxt;
  logic               advance;

  // free for a new group when idle or when the last byte leaves now
  assign advance = !busy_r || (out_tready && idx_r == BYTE_IDX_LAST);
  assign pop     = advance && !fifo_stat.empty;

  assign out_tvalid = busy_r;
  assign out_tlast  = (idx_r == BYTE_IDX_LAST);

  always_comb begin
    case (idx_r)
      BYTE_IDX_FIRST: out_tdata = word_r[GROUP_W-1 -: BYTE_W];
      BYTE_IDX_MID:   out_tdata = word_r[GROUP_W-BYTE_W-1 -: BYTE_W];
      default:        out_tdata = word_r[BYTE_W-1:0];
    endcase
  end

  always_comb begin
    word_nxt = word_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (busy_r && out_tready && idx_r != BYTE_IDX_LAST) begin
      idx_nxt = idx_r + 2'd1;
    end
    if (advance) begin
      if (!fifo_stat.empty) begin
        word_nxt = pop_data;
        idx_nxt  = BYTE_IDX_FIRST;
        busy_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= BYTE_IDX_FIRST;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
    word_r <= word_nxt;
  end

endmodule

@@ hw/rtl/base64_stream_decoder_core.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character in, three bytes out per group.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)  | tlast
//  --------+-----+---------------------+-------------------------------
//  in_     | in  | [7:0] in_char       | msg_end: last char of message
//  out_    | out | [7:0] out_byte      | run_last: third byte of group
//
//  Flow: one character accepted per cycle while the group queue is not
//  full; four characters make a group, which leaves as three bytes,
//  first to last; the unpacker takes the next group as its last byte leaves.
//  Reset: synchronous, active low; clears the partial group, the group
//  queue and the output stage.
//  Stalls: a queue of FIFO_DEPTH groups sits between the character front
//  and the byte unpacker; in_tready drops only while that queue is full.
//  Characters outside the alphabet, '=' included, are dropped; msg_end
//  discards any partial group.
//
module base64_stream_decoder_core #(
  parameter int unsigned FIFO_DEPTH = b64d_pkg::B64D_FIFO_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [b64d_pkg::BYTE_W-1:0]  in_tdata,   // [7:0] in_char
  input  logic                         in_tlast,   // msg_end
  // output words
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [b64d_pkg::BYTE_W-1:0]  out_tdata,  // [7:0] out_byte
  output logic                         out_tlast   // run_last
);
  import b64d_pkg::*;

  fifo_stat_t          fifo_stat;
  logic                push;
  logic                pop;
  logic [GROUP_W-1:0]  push_data;
  logic [GROUP_W-1:0]  pop_data;

  // character classification and group packing
  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the character side from the byte side
  b64d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fifo_stat)
  );

  // group to byte unpacking with registered output
  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
